// ----- hdl/apts_pkg.sv -----
`timescale 1ns / 1ps

package apts_pkg;

    localparam int BSSID_W    = 48;
    localparam int RSSI_W     = 16;
    localparam int CHAN_W     = 8;
    localparam int SEC_W      = 8;
    localparam int SSID_WORDS = 4;
    localparam int SSID_W     = 64;
    localparam int SLOT_W     = 5;
    localparam int USED_W     = 6;

    typedef enum logic [1:0] {
        MODE_REPORT = 2'd0,
        MODE_READ   = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // One table entry as it sits in the RAM.
    typedef struct packed {
        logic [BSSID_W-1:0]                   bssid;
        logic signed [RSSI_W-1:0]             rssi;
        logic [CHAN_W-1:0]                    channel;
        logic [SEC_W-1:0]                     security;
        logic [SSID_WORDS-1:0][SSID_W-1:0]    ssid;
    } entry_t;

    typedef struct packed {
        logic [1:0]        mode;
        entry_t            ap;
        logic [SLOT_W-1:0] read_slot;
    } req_t;

    typedef struct packed {
        logic   accepted;
        logic   slot_valid;
        entry_t entry;
    } res_t;

endpackage

// ----- hdl/access_point_table_sorted.sv -----
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_ready   mode, ap_bssid, ap_rssi, ap_channel, ap_security,
//                                ssid_word0..ssid_word3, read_slot
// out      out_valid / out_ready accepted, slot_valid, slot_bssid, slot_rssi, slot_channel,
//                                slot_security, slot_ssid0..slot_ssid3, used_count
//
// One item at a time. A report searches the valid entries for its address, writes the updated
// or new entry (a new address is dropped when the table is full) and then sorts the table by
// RSSI, strongest first; a read and a clear skip the search and the sort. The table RAM, with
// one read port and one write port, sets the pace. After reset the table is empty; no clearing
// pass is needed since the valid entries always form a prefix tracked by a count. A stalled
// output holds its result while the next item is taken in and worked on.

module access_point_table_sorted #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          mode,
    input  logic [47:0]         ap_bssid,
    input  logic signed [15:0]  ap_rssi,
    input  logic [7:0]          ap_channel,
    input  logic [7:0]          ap_security,
    input  logic [63:0]         ssid_word0,
    input  logic [63:0]         ssid_word1,
    input  logic [63:0]         ssid_word2,
    input  logic [63:0]         ssid_word3,
    input  logic [4:0]          read_slot,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                accepted,
    output logic                slot_valid,
    output logic [47:0]         slot_bssid,
    output logic signed [15:0]  slot_rssi,
    output logic [7:0]          slot_channel,
    output logic [7:0]          slot_security,
    output logic [63:0]         slot_ssid0,
    output logic [63:0]         slot_ssid1,
    output logic [63:0]         slot_ssid2,
    output logic [63:0]         slot_ssid3,
    output logic [5:0]          used_count
);

    import apts_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    req_t          req;
    res_t          res;
    logic          res_valid;
    logic          res_ready;
    logic [CW-1:0] count;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    logic               out_valid_reg;
    res_t               out_res_reg;
    logic [USED_W-1:0]  used_reg;

    // The input item is gathered into one request word for the controller.
    always_comb
    begin
        req              = '0;
        req.mode         = mode;
        req.ap.bssid     = ap_bssid;
        req.ap.rssi      = ap_rssi;
        req.ap.channel   = ap_channel;
        req.ap.security  = ap_security;
        req.ap.ssid[0]   = ssid_word0;
        req.ap.ssid[1]   = ssid_word1;
        req.ap.ssid[2]   = ssid_word2;
        req.ap.ssid[3]   = ssid_word3;
        req.read_slot    = read_slot;
    end

    apts_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req      (req),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res),
        .count    (count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data)
    );

    // All entries live in one RAM, one whole entry per word.
    apts_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // The output register lets the controller hand off a result and move on.
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
            used_reg    <= USED_W'(count);
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = out_res_reg.accepted;
    assign slot_valid    = out_res_reg.slot_valid;
    assign slot_bssid    = out_res_reg.entry.bssid;
    assign slot_rssi     = out_res_reg.entry.rssi;
    assign slot_channel  = out_res_reg.entry.channel;
    assign slot_security = out_res_reg.entry.security;
    assign slot_ssid0    = out_res_reg.entry.ssid[0];
    assign slot_ssid1    = out_res_reg.entry.ssid[1];
    assign slot_ssid2    = out_res_reg.entry.ssid[2];
    assign slot_ssid3    = out_res_reg.entry.ssid[3];
    assign used_count    = used_reg;

    // The table never holds more entries than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n) count <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    // A result is either a stored report or a read hit, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(accepted && slot_valid))
        else $error("result marked both stored and read");

    // A stored report leaves at least one entry in the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready && res.accepted) |-> (count != '0))
        else $error("stored report with empty table");

    // The controller takes no new item while a result is still pending in it.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !in_ready)
        else $error("input taken while result pending");

endmodule

// ----- hdl/apts_ram.sv -----
`timescale 1ns / 1ps

module apts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/apts_ctrl.sv -----
`timescale 1ns / 1ps

module apts_ctrl #(
    parameter int TABLE_DEPTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  apts_pkg::req_t    req,
    output logic              res_valid,
    input  logic              res_ready,
    output apts_pkg::res_t    res,
    output logic [CW-1:0]     count,
    output logic              wr_en,
    output logic [AW-1:0]     wr_addr,
    output apts_pkg::entry_t  wr_data,
    output logic [AW-1:0]     rd_addr,
    input  apts_pkg::entry_t  rd_data
);

    import apts_pkg::*;

    localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_UPD, S_SLD, S_SCUR, S_SCMP, S_SWB, S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    req_t          req_reg, req_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic          hit_reg, hit_next;
    logic          rd_reg, rd_next;
    entry_t        cur_reg, cur_next;
    res_t          res_reg, res_next;
    entry_t        upd_e;
    logic          addr_last;
    logic          i_last;

    assign addr_last = (CW'(addr_reg) + CW'(1)) == count_reg;
    assign i_last    = (CW'(i_reg) + CW'(2)) == count_reg;

    // Matched entry keeps its name and address; a new one takes them from the item.
    always_comb
    begin
        upd_e          = cur_reg;
        upd_e.rssi     = req_reg.ap.rssi;
        upd_e.channel  = req_reg.ap.channel;
        upd_e.security = req_reg.ap.security;
        if (!hit_reg)
        begin
            upd_e.bssid = req_reg.ap.bssid;
            upd_e.ssid  = req_reg.ap.ssid;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        req_next   = req_reg;
        addr_next  = addr_reg;
        i_next     = i_reg;
        slot_next  = slot_reg;
        hit_next   = hit_reg;
        rd_next    = rd_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        rd_addr    = addr_reg + AW'(1);
        wr_en      = 1'b0;
        wr_addr    = addr_reg;
        wr_data    = cur_reg;
        case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                rd_next = 1'b0;
                if (in_valid)
                begin
                    req_next = req;
                    res_next = '0;
                    case (req.mode)
                        MODE_REPORT:
                        begin
                            addr_next = '0;
                            if (count_reg == '0)
                            begin
                                hit_next   = 1'b0;
                                slot_next  = '0;
                                state_next = S_UPD;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        MODE_READ:
                        begin
                            rd_addr    = AW'(req.read_slot);
                            rd_next    = CMPW'(req.read_slot) < CMPW'(count_reg);
                            state_next = S_DONE;
                        end
                        MODE_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_data.bssid == req_reg.ap.bssid)
                begin
                    hit_next   = 1'b1;
                    slot_next  = addr_reg;
                    cur_next   = rd_data;
                    state_next = S_UPD;
                end
                else if (addr_last)
                begin
                    if (count_reg == CW'(TABLE_DEPTH))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        hit_next   = 1'b0;
                        slot_next  = AW'(count_reg);
                        state_next = S_UPD;
                    end
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_UPD:
            begin
                wr_en             = 1'b1;
                wr_addr           = slot_reg;
                wr_data           = upd_e;
                res_next.accepted = 1'b1;
                i_next            = '0;
                if (!hit_reg)
                begin
                    count_next = count_reg + CW'(1);
                end
                if ((hit_reg && count_reg < CW'(2)) || (!hit_reg && count_reg == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SLD;
                end
            end
            S_SLD:
            begin
                rd_addr    = i_reg;
                state_next = S_SCUR;
            end
            S_SCUR:
            begin
                cur_next   = rd_data;
                rd_addr    = i_reg + AW'(1);
                addr_next  = i_reg + AW'(1);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (rd_data.rssi > cur_reg.rssi)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = addr_reg;
                    wr_data  = cur_reg;
                    cur_next = rd_data;
                end
                if (addr_last)
                begin
                    state_next = S_SWB;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_SWB:
            begin
                wr_en   = 1'b1;
                wr_addr = i_reg;
                wr_data = cur_reg;
                rd_addr = i_reg + AW'(1);
                if (i_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_SCUR;
                end
            end
            S_DONE:
            begin
                // A read result lands here in the cycle after its RAM access.
                if (rd_reg)
                begin
                    res_next.slot_valid = 1'b1;
                    res_next.entry      = rd_data;
                    rd_next             = 1'b0;
                end
                else if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rd_reg    <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rd_reg    <= rd_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        addr_reg <= addr_next;
        i_reg    <= i_next;
        slot_reg <= slot_next;
        cur_reg  <= cur_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE) && !rd_reg;
    assign res       = res_reg;
    assign count     = count_reg;

endmodule

// ----- verif/apts_checker.sv -----
`timescale 1ns / 1ps

module apts_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [47:0]        ap_bssid,
    input  logic signed [15:0] ap_rssi,
    input  logic [7:0]         ap_channel,
    input  logic [7:0]         ap_security,
    input  logic [63:0]        ssid_word0,
    input  logic [63:0]        ssid_word1,
    input  logic [63:0]        ssid_word2,
    input  logic [63:0]        ssid_word3,
    input  logic [4:0]         read_slot,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic               accepted,
    input  logic               slot_valid,
    input  logic [47:0]        slot_bssid,
    input  logic signed [15:0] slot_rssi,
    input  logic [7:0]         slot_channel,
    input  logic [7:0]         slot_security,
    input  logic [63:0]        slot_ssid0,
    input  logic [63:0]        slot_ssid1,
    input  logic [63:0]        slot_ssid2,
    input  logic [63:0]        slot_ssid3,
    input  logic [5:0]         used_count,
    output int                 fail_count,
    output int                 pending
);

    import apts_pkg::*;

    localparam int DEPTH = 32;

    typedef struct packed {
        logic   accepted;
        logic   slot_valid;
        entry_t entry;
        logic [USED_W-1:0] used;
    } table_answer_t;

    logic   tbl_valid [DEPTH];
    entry_t tbl_entry [DEPTH];
    table_answer_t answers[$];

    assign pending = answers.size();

    function automatic int count_entries();
        int n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (tbl_valid[i])
                n++;
        return n;
    endfunction

    // Applies one item to the shadow table and returns the answer it should give.
    function automatic table_answer_t apply_item(mode_t m, entry_t ap, logic [4:0] s);
        table_answer_t a;
        int            slot;
        logic          tv;
        entry_t        te;
        a    = '0;
        slot = -1;
        if (m == MODE_REPORT) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!tbl_valid[i]) begin
                    if (slot < 0)
                        slot = i;
                end else if (tbl_entry[i].bssid == ap.bssid) begin
                    slot = i;
                    break;
                end
            end
            if (slot >= 0) begin
                if (!tbl_valid[slot]) begin
                    tbl_entry[slot].bssid = ap.bssid;
                    tbl_entry[slot].ssid  = ap.ssid;
                    tbl_valid[slot]       = 1'b1;
                end
                tbl_entry[slot].rssi     = ap.rssi;
                tbl_entry[slot].channel  = ap.channel;
                tbl_entry[slot].security = ap.security;
                for (int i = 0; i < DEPTH - 1; i++) begin
                    if (!tbl_valid[i])
                        continue;
                    for (int j = i + 1; j < DEPTH; j++) begin
                        if (tbl_valid[j] && $signed(tbl_entry[j].rssi) > $signed(tbl_entry[i].rssi))
                        begin
                            tv           = tbl_valid[i];
                            te           = tbl_entry[i];
                            tbl_valid[i] = tbl_valid[j];
                            tbl_entry[i] = tbl_entry[j];
                            tbl_valid[j] = tv;
                            tbl_entry[j] = te;
                        end
                    end
                end
                a.accepted = 1'b1;
            end
        end else if (m == MODE_READ) begin
            if (tbl_valid[s]) begin
                a.slot_valid = 1'b1;
                a.entry      = tbl_entry[s];
            end
        end else if (m == MODE_CLEAR) begin
            for (int i = 0; i < DEPTH; i++)
                tbl_valid[i] = 1'b0;
        end
        a.used = USED_W'(count_entries());
        return a;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        table_answer_t want;
        table_answer_t got;
        entry_t        ap;
        if (!rst_n) begin
            for (int i = 0; i < DEPTH; i++)
            begin
                tbl_valid[i] = 1'b0;
                tbl_entry[i] = '0;
            end
            answers.delete();
            fail_count <= 0;
        end else begin
            if (out_valid && out_ready) begin
                got = {accepted, slot_valid, slot_bssid, slot_rssi, slot_channel,
                       slot_security, slot_ssid3, slot_ssid2, slot_ssid1, slot_ssid0,
                       used_count};
                if (answers.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result %h", $realtime, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = answers.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                        begin
                            $display("%0t: mismatch acc %b/%b valid %b/%b used %0d/%0d",
                                     $realtime, want.accepted, got.accepted,
                                     want.slot_valid, got.slot_valid, want.used, got.used);
                            $display("    entry expected %h", want.entry);
                            $display("    entry actual   %h", got.entry);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready) begin
                ap.bssid    = ap_bssid;
                ap.rssi     = ap_rssi;
                ap.channel  = ap_channel;
                ap.security = ap_security;
                ap.ssid     = {ssid_word3, ssid_word2, ssid_word1, ssid_word0};
                answers.push_back(apply_item(mode_t'(mode), ap, read_slot));
            end
        end
    end

endmodule

// ----- verif/tb_access_point_table_sorted.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted access point table. The checker beside the
// block keeps a shadow table and compares every result item.
module tb_access_point_table_sorted;
    import apts_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         mode;
    logic [47:0]        ap_bssid;
    logic signed [15:0] ap_rssi;
    logic [7:0]         ap_channel;
    logic [7:0]         ap_security;
    logic [63:0]        ssid_word0;
    logic [63:0]        ssid_word1;
    logic [63:0]        ssid_word2;
    logic [63:0]        ssid_word3;
    logic [4:0]         read_slot;
    logic               out_valid;
    logic               out_ready;
    logic               accepted;
    logic               slot_valid;
    logic [47:0]        slot_bssid;
    logic signed [15:0] slot_rssi;
    logic [7:0]         slot_channel;
    logic [7:0]         slot_security;
    logic [63:0]        slot_ssid0;
    logic [63:0]        slot_ssid1;
    logic [63:0]        slot_ssid2;
    logic [63:0]        slot_ssid3;
    logic [5:0]         used_count;
    int                 fail_count;
    int                 pending;

    // A small pool of addresses makes updates of existing entries common.
    logic [47:0] bssid_pool[48];
    // When set, the receiver takes a long break to back the block up.
    logic        sink_hold;

    access_point_table_sorted i_dut (.*);

    apts_checker i_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    // Offers one item and waits until the block takes it. Valid stays high so that
    // the next item can follow at once.
    task automatic send_item(mode_t m, logic [47:0] b, logic [15:0] r, logic [4:0] s);
        in_valid    <= 1'b1;
        mode        <= m;
        ap_bssid    <= b;
        ap_rssi     <= r;
        ap_channel  <= 8'($urandom);
        ap_security <= 8'($urandom);
        ssid_word0  <= {$urandom, $urandom};
        ssid_word1  <= {$urandom, $urandom};
        ssid_word2  <= {$urandom, $urandom};
        ssid_word3  <= {$urandom, $urandom};
        read_slot   <= s;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_gap();
        int n;
        n = gap_len();
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] random_rssi();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom);
            default: return 16'($signed(-$urandom_range(20, 95)));
        endcase
    endfunction

    function automatic logic [4:0] random_slot();
        return 5'($urandom);
    endfunction

    // The receiver stalls at random; when asked, it holds off for a fixed long stretch.
    initial
    begin
        int n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                out_ready <= 1'b1;
                wait (!sink_hold);
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                n = gap_len();
                if (n > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                out_ready <= 1'b1;
            end else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #50ms;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [47:0] b;
        rst_n       = 1'b0;
        sink_hold   = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_NONE;
        ap_bssid    = '0;
        ap_rssi     = '0;
        ap_channel  = '0;
        ap_security = '0;
        ssid_word0  = '0;
        ssid_word1  = '0;
        ssid_word2  = '0;
        ssid_word3  = '0;
        read_slot   = '0;
        for (int i = 0; i < 48; i++)
            bssid_pool[i] = {$urandom, $urandom};
        bssid_pool[0] = '0;
        bssid_pool[1] = '1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reads of an empty table, extreme values, an update of a
        // known address, a read past the occupied slots, the unused mode and a clear.
        send_item(MODE_READ, '0, '0, 5'd0);
        send_item(MODE_READ, '0, '0, 5'd31);
        send_item(MODE_REPORT, bssid_pool[0], 16'h8000, '0);
        send_item(MODE_REPORT, bssid_pool[1], 16'h7FFF, '1);
        send_item(MODE_REPORT, bssid_pool[2], 16'hFFC4, '0);
        send_item(MODE_REPORT, bssid_pool[0], 16'h0000, '0);
        for (int s = 0; s < 4; s++)
            send_item(MODE_READ, '0, '0, 5'(s));
        send_item(MODE_READ, '0, '0, 5'd31);
        send_item(MODE_NONE, '1, '1, '1);
        send_item(MODE_CLEAR, '0, '0, '0);
        send_item(MODE_READ, '0, '0, 5'd0);
        // Stale data in a freed slot must not match a new report.
        send_item(MODE_REPORT, bssid_pool[1], 16'h0001, '0);
        send_item(MODE_READ, '0, '0, 5'd0);

        // Fill the table past its capacity so that reports get dropped.
        for (int i = 0; i < 36; i++)
            send_item(MODE_REPORT, {$urandom, $urandom}, random_rssi(), '0);
        for (int s = 0; s < 32; s += 7)
            send_item(MODE_READ, '0, '0, 5'(s));
        send_item(MODE_REPORT, bssid_pool[1], 16'h7FFF, '0);
        send_item(MODE_READ, '0, '0, 5'd0);

        // Long receiver hold-off while items keep coming, so the input stalls.
        sink_hold <= 1'b1;
        for (int i = 0; i < 6; i++)
            send_item(MODE_READ, '0, '0, random_slot());
        sink_hold <= 1'b0;

        // Random part: mostly reports over a reused address pool and reads, with
        // occasional clears and unused mode codes.
        for (int i = 0; i < 780; i++)
        begin
            idle_gap();
            case ($urandom_range(0, 99)) inside
                [0:54]:
                begin
                    b = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                                    : bssid_pool[$urandom_range(0, 47)];
                    send_item(MODE_REPORT, b, random_rssi(), random_slot());
                end
                [55:94]: send_item(MODE_READ, {$urandom, $urandom}, 16'($urandom),
                                   random_slot());
                [95:97]: send_item(MODE_CLEAR, {$urandom, $urandom}, 16'($urandom),
                                   random_slot());
                default: send_item(MODE_NONE, {$urandom, $urandom}, 16'($urandom),
                                   random_slot());
            endcase
            // Once in a while the sender waits until every result is back.
            if (i % 200 == 100)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
